/* sv/text_console_writer_macros.svh */
// Assertion macros for the text console writer.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

`ifndef SYNTHESIS
`define TCW_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("check failed");
`define TCW_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("check failed");
`else
`define TCW_ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define TCW_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

/* sv/tcw_pkg.sv */
// Shared constants and types for the text console writer.
// No dependencies; imported by tcw_cursor, text_console_writer and the testbench.
`default_nettype none

package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = 7;
    localparam int ROW_W      = 5;

    localparam logic [15:0] RESET_CELL   = 16'h0720;
    localparam logic [7:0]  RESET_ATTR   = 8'h07;
    localparam logic [7:0]  SPACE_CHAR   = 8'h20;
    localparam logic [7:0]  NEWLINE_CHAR = 8'd10;
    localparam logic [7:0]  NULL_CHAR    = 8'd0;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] addr;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              scroll;
    } cursor_step_t;

endpackage

`default_nettype wire

/* sv/tcw_cursor.sv */
// Cursor advance for one put: cell address, wrap, newline and scroll request.
// Depends on tcw_pkg.
`default_nettype none

module tcw_cursor (
    input  wire logic [tcw_pkg::COL_W-1:0] col,
    input  wire logic [tcw_pkg::ROW_W-1:0] row,
    input  wire logic [7:0]                char_code,
    output tcw_pkg::cursor_step_t          step
);
    import tcw_pkg::*;

    logic [ADDR_W-1:0] row_base;
    logic [COL_W:0]    col_inc;
    logic [ROW_W:0]    row_inc;
    logic              advance;

    assign row_base = ADDR_W'(row) * ADDR_W'(COLUMNS);
    assign col_inc  = {1'b0, col} + (COL_W+1)'(1);
    assign row_inc  = {1'b0, row} + (ROW_W+1)'(1);

    always_comb begin
        step.wr_en  = 1'b0;
        step.addr   = row_base + ADDR_W'(col);
        step.col    = col;
        step.row    = row;
        step.scroll = 1'b0;
        advance     = 1'b0;
        if (char_code == NEWLINE_CHAR) begin
            step.col = '0;
            advance  = 1'b1;
        end else if (char_code != NULL_CHAR) begin
            step.wr_en = 1'b1;
            if (col_inc >= (COL_W+1)'(COLUMNS)) begin
                step.col = '0;
                advance  = 1'b1;
            end else begin
                step.col = col_inc[COL_W-1:0];
            end
        end
        if (advance) begin
            if (row_inc >= (ROW_W+1)'(ROWS)) begin
                step.row    = ROW_W'(ROWS - 1);
                step.scroll = 1'b1;
            end else begin
                step.row = row_inc[ROW_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

/* sv/text_console_writer.sv */
// Text console writer top level: cell store, sequencer and stream ports.
// Depends on tcw_pkg, tcw_cursor and text_console_writer_macros.svh.
//
// Usage:
//   s_ channel carries one command beat: s_tuser is the operation (put,
//   clear, read), s_tdata the character and the cell index. m_ channel
//   returns one beat per command: read data (zero unless a read) and the
//   cursor column and row after the command.
//   cfg_wr_en/cfg_wr_data load the attribute byte for written and blank
//   cells; write it only while no command is in flight.
// Sequence (accept to result; output free):
//   put, ignored code, newline: ST_DONE; read: ST_RDWAIT, ST_DONE; clear: ST_FILL
//   over all cells, ST_DONE; put that scrolls: ST_COPY loop over the store (one
//   cell per cycle), ST_FILL of the bottom row, ST_DONE.
//   One command is in work at a time; s_tready is high only when idle.
// Reset: aresetn low for one edge; afterwards the store is swept to
//   0x0720, one cell a cycle, over all CELL_COUNT (2000) cells with s_tready
//   low. Cursor returns home, attribute returns to 0x07.
// Stall: a result waits in the output register while m_tready is low;
//   the next command may be accepted, but its result waits behind it.
`default_nettype none

`include "text_console_writer_macros.svh"

module text_console_writer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,  // [7:0] char_code, [18:8] cell_index, [23:19] zero
    input  wire logic [1:0]  s_tuser,  // [1:0] operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata   // [15:0] read_data, [22:16] cursor_column,
                                       // [27:23] cursor_row, [31:28] zero
);
    import tcw_pkg::*;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_RDWAIT,
        ST_COPY,
        ST_FILL,
        ST_DONE
    } state_t;

    localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] COPY_START  = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] BOTTOM_BASE = ADDR_W'(COLUMNS * (ROWS - 1));

    state_t            state_reg, state_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [7:0]        attr_reg, attr_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [ADDR_W-1:0] wr_addr_reg, wr_addr_next;
    logic              pend_reg, pend_next;
    logic              rd_done_reg, rd_done_next;
    logic [15:0]       fill_value_reg, fill_value_next;
    logic [15:0]       res_data_reg, res_data_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [31:0]       m_tdata_reg, m_tdata_next;

    logic [15:0]       cells_mem [CELL_COUNT];
    logic [15:0]       cell_rd_reg;
    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic [15:0]       mem_wr_data;
    logic              mem_rd_en;
    logic [ADDR_W-1:0] mem_rd_addr;

    logic [1:0]        in_op;
    logic [7:0]        in_char;
    logic [10:0]       in_index;
    logic              in_fire;
    logic [15:0]       blank;
    cursor_step_t      step;

    assign in_op    = s_tuser;
    assign in_char  = s_tdata[7:0];
    assign in_index = s_tdata[18:8];
    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign blank    = {attr_reg, SPACE_CHAR};
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    tcw_cursor u_cursor (
        .col       (col_reg),
        .row       (row_reg),
        .char_code (in_char),
        .step      (step)
    );

    always_comb begin
        state_next      = state_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        attr_next       = cfg_wr_en ? cfg_wr_data : attr_reg;
        ptr_next        = ptr_reg;
        wr_addr_next    = wr_addr_reg;
        pend_next       = 1'b0;
        rd_done_next    = rd_done_reg;
        fill_value_next = fill_value_reg;
        res_data_next   = res_data_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = ptr_reg;
        mem_wr_data     = fill_value_reg;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = ptr_reg;

        unique case (state_reg)
            ST_INIT: begin
                mem_wr_en = 1'b1;
                if (ptr_reg == LAST_ADDR) begin
                    state_next = ST_IDLE;
                end else begin
                    ptr_next = ptr_reg + ADDR_W'(1);
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    res_data_next = '0;
                    state_next    = ST_DONE;
                    unique case (in_op)
                        OP_PUT: begin
                            mem_wr_en   = step.wr_en;
                            mem_wr_addr = step.addr;
                            mem_wr_data = {attr_reg, in_char};
                            col_next    = step.col;
                            row_next    = step.row;
                            if (step.scroll) begin
                                ptr_next        = COPY_START;
                                rd_done_next    = 1'b0;
                                fill_value_next = blank;
                                state_next      = ST_COPY;
                            end
                        end
                        OP_CLEAR: begin
                            col_next        = '0;
                            row_next        = '0;
                            ptr_next        = '0;
                            fill_value_next = blank;
                            state_next      = ST_FILL;
                        end
                        OP_READ: begin
                            if (in_index < 11'(CELL_COUNT)) begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = in_index[ADDR_W-1:0];
                                state_next  = ST_RDWAIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RDWAIT: begin
                res_data_next = cell_rd_reg;
                state_next    = ST_DONE;
            end
            ST_COPY: begin
                mem_wr_en   = pend_reg;
                mem_wr_addr = wr_addr_reg;
                mem_wr_data = cell_rd_reg;
                if (rd_done_reg) begin
                    ptr_next   = BOTTOM_BASE;
                    state_next = ST_FILL;
                end else begin
                    mem_rd_en    = 1'b1;
                    pend_next    = 1'b1;
                    wr_addr_next = ptr_reg - COPY_START;
                    if (ptr_reg == LAST_ADDR) begin
                        rd_done_next = 1'b1;
                    end else begin
                        ptr_next = ptr_reg + ADDR_W'(1);
                    end
                end
            end
            ST_FILL: begin
                mem_wr_en = 1'b1;
                if (ptr_reg == LAST_ADDR) begin
                    state_next = ST_DONE;
                end else begin
                    ptr_next = ptr_reg + ADDR_W'(1);
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0, row_reg, col_reg, res_data_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_INIT;
            col_reg        <= '0;
            row_reg        <= '0;
            attr_reg       <= RESET_ATTR;
            ptr_reg        <= '0;
            pend_reg       <= 1'b0;
            rd_done_reg    <= 1'b0;
            fill_value_reg <= RESET_CELL;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            attr_reg       <= attr_next;
            ptr_reg        <= ptr_next;
            pend_reg       <= pend_next;
            rd_done_reg    <= rd_done_next;
            fill_value_reg <= fill_value_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        wr_addr_reg  <= wr_addr_next;
        res_data_reg <= res_data_next;
        m_tdata_reg  <= m_tdata_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_wr_en) begin
            cells_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en) begin
            cell_rd_reg <= cells_mem[mem_rd_addr];
        end
    end

    `TCW_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, in_fire, !s_tready)
    `TCW_ASSERT_IMPLY(a_row_in_range, aclk, aresetn, m_tvalid, m_tdata[27:23] < ROW_W'(ROWS))
    `TCW_ASSERT_IMPLY(a_result_from_done, aclk, aresetn, $rose(m_tvalid),
                      $past(state_reg) == ST_DONE)
    `TCW_ASSERT_NEXT(a_copy_then_fill, aclk, aresetn, state_reg == ST_COPY,
                     state_reg == ST_COPY || state_reg == ST_FILL)

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for text_console_writer: command beats in, status beats out.
// Depends on tcw_pkg and the text_console_writer RTL; a scoreboard class predicts each status.
`default_nettype none

module testbench;
    import tcw_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    class console_scoreboard;
        logic [15:0] cells [CELL_COUNT];
        int unsigned col;
        int unsigned row;
        logic [7:0]  attr;
        logic [31:0] awaited_status [$];
        int          errors;

        function new();
            for (int i = 0; i < CELL_COUNT; i++) cells[i] = RESET_CELL;
            col = 0;
            row = 0;
            attr = RESET_ATTR;
            errors = 0;
        endfunction

        function void set_attr(logic [7:0] value);
            attr = value;
        endfunction

        function int pending();
            return awaited_status.size();
        endfunction

        function void blank_from(int first);
            for (int i = first; i < CELL_COUNT; i++) cells[i] = {attr, SPACE_CHAR};
        endfunction

        function void accept_command(logic [1:0] op, logic [7:0] ch, logic [10:0] idx);
            logic [15:0] data;
            data = '0;
            case (op)
                OP_PUT: begin
                    if (ch != NULL_CHAR) begin
                        if (ch == NEWLINE_CHAR) begin
                            col = 0;
                            row++;
                        end else begin
                            cells[row * COLUMNS + col] = {attr, ch};
                            col++;
                            if (col >= COLUMNS) begin
                                col = 0;
                                row++;
                            end
                        end
                        if (row >= ROWS) begin
                            for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
                                cells[i] = cells[i + COLUMNS];
                            blank_from(CELL_COUNT - COLUMNS);
                            row = ROWS - 1;
                        end
                    end
                end
                OP_CLEAR: begin
                    blank_from(0);
                    col = 0;
                    row = 0;
                end
                OP_READ: begin
                    if (idx < CELL_COUNT) data = cells[idx];
                end
                default: ;
            endcase
            awaited_status.push_back({4'd0, ROW_W'(row), COL_W'(col), data});
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch in %s: got %h, want %h", what, got, want);
            errors++;
        endtask

        task check_status(logic [31:0] beat);
            logic [31:0] want;
            if (awaited_status.size() == 0) begin
                report("status beat with nothing awaited", beat, '0);
                return;
            end
            want = awaited_status.pop_front();
            if (beat[15:0] !== want[15:0]) report("read_data", beat, want);
            if (beat[22:16] !== want[22:16]) report("cursor_column", beat, want);
            if (beat[27:23] !== want[27:23]) report("cursor_row", beat, want);
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;  // [7:0] char_code, [18:8] cell_index, [23:19] zero
    logic [1:0]  s_tuser = '0;  // [1:0] operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;       // [15:0] read_data, [22:16] cursor_column, [27:23] cursor_row
    bit          steady = 1'b0;

    console_scoreboard sb = new();

    text_console_writer u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #2 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 6);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_status(m_tdata);
    end

    task automatic send_beat(input logic [1:0] op, input logic [7:0] ch, input logic [10:0] idx);
        if (!steady && $urandom_range(0, 99) < 6) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tuser = op;
        s_tdata = {5'd0, idx, ch};
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.accept_command(op, ch, idx);
        @(negedge aclk);
    endtask

    task automatic settle();
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_attr(input logic [7:0] value);
        settle();
        cfg_wr_data = value;
        cfg_wr_en = 1'b1;
        @(posedge aclk);
        sb.set_attr(value);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic random_commands(input int count, input int newline_rate);
        int unsigned pick;
        logic [1:0]  op;
        logic [7:0]  ch;
        logic [10:0] idx;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 999);
            op = OP_PUT;
            ch = 8'($urandom_range(1, 255));
            idx = 11'($urandom_range(0, 2047));
            if (pick < 2) begin
                op = OP_CLEAR;
            end else if (pick < 220) begin
                op = OP_READ;
                if (pick < 140) idx = 11'(sb.row * COLUMNS + $urandom_range(0, COLUMNS - 1));
            end else if (pick < 240) begin
                op = OP_UNUSED;
            end else if (pick < 255) begin
                ch = NULL_CHAR;
            end else if (pick < 255 + newline_rate) begin
                ch = NEWLINE_CHAR;
            end
            if (pick >= 996) settle();
            send_beat(op, ch, idx);
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        send_beat(OP_READ, 8'h00, 11'd0);
        send_beat(OP_READ, 8'hFF, 11'd1999);
        send_beat(OP_READ, 8'h00, 11'd2000);
        send_beat(OP_READ, 8'hFF, 11'd2047);
        send_beat(OP_UNUSED, 8'hFF, 11'd2047);
        send_beat(OP_PUT, NULL_CHAR, 11'd2047);
        send_beat(OP_PUT, 8'hFF, 11'd0);
        send_beat(OP_PUT, 8'h01, 11'd0);
        send_beat(OP_PUT, 8'h80, 11'd0);
        send_beat(OP_PUT, NEWLINE_CHAR, 11'd0);
        send_beat(OP_PUT, 8'h7F, 11'd0);
        send_beat(OP_READ, 8'h00, 11'd0);
        send_beat(OP_READ, 8'h00, 11'd1);
        send_beat(OP_READ, 8'h00, 11'd2);
        send_beat(OP_READ, 8'h00, 11'd3);
        send_beat(OP_READ, 8'h00, 11'd80);
        send_beat(OP_READ, 8'h00, 11'd81);
        send_beat(OP_CLEAR, 8'hFF, 11'd2047);
        send_beat(OP_READ, 8'h00, 11'd0);
        send_beat(OP_READ, 8'h00, 11'd80);
        send_beat(OP_PUT, SPACE_CHAR, 11'd0);
        send_beat(OP_UNUSED, 8'h00, 11'd0);

        random_commands(300, 60);
        write_attr(8'h00);
        steady = 1'b1;
        random_commands(300, 60);
        steady = 1'b0;
        write_attr(8'hFF);
        random_commands(300, 10);
        write_attr(8'($urandom_range(0, 255)));
        random_commands(300, 60);
        write_attr(8'($urandom_range(0, 255)));
        random_commands(300, 30);
        write_attr(RESET_ATTR);
        random_commands(300, 80);

        settle();
        repeat (2100) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #80_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

/* text_console_writer.f */
+incdir+sv
sv/tcw_pkg.sv
sv/tcw_cursor.sv
sv/text_console_writer.sv
sim/testbench.sv
